### rtl/fla_pkg.sv
// Shared types, codes and helpers of the free-list block allocator.
// No dependencies; used by the controller, datapath and top level.
package fla_pkg;

  // Default build-time sizes
  localparam int ADDR_BITS_DEF    = 16;
  localparam int FREE_SLOTS_DEF   = 32;
  localparam int ALLOC_SLOTS_DEF  = 32;
  localparam int HEADER_BYTES_DEF = 16;

  // Largest pool the offsets can address
  localparam logic [16:0] POOL_LIM =
    (ADDR_BITS_DEF < 16) ? 17'(1 << ADDR_BITS_DEF) : 17'd65536;

  // Request limits
  localparam logic [15:0] MIN_REQUEST    = 16'd16;
  localparam logic [3:0]  MIN_ALIGN_LOG2 = 4'd3;
  localparam logic [3:0]  MAX_ALIGN_LOG2 = 4'd12;
  localparam logic [16:0] POOL_MIN       = 17'd64;

  // Register index (paddr bit 2)
  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_POOL_BYTES = 1'b1;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_RESET = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_FIT  = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_BAD     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ASCAN,
    S_ACHK,
    S_FLOOK,
    S_FPOS,
    S_FPREV,
    S_FCHK,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_clr;
    logic    scan_step;
    logic    alloc_commit;
    logic    look_clr;
    logic    look_step;
    logic    pos_step;
    logic    prev_eval;
    logic    free_commit;
    logic    pool_reset;
    logic    st_we;
    status_t st_code;
    logic    resp_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  req_bad;
    logic  scan_done;
    logic  found;
    logic  slot_avail;
    logic  look_hit;
    logic  look_last;
    logic  pos_done;
    logic  jprev;
    logic  jnext;
    logic  table_full;
    logic  out_busy;
  } sts_t;

  // Header plus alignment padding in front of a block starting at base
  function automatic logic [16:0] pad_for(input logic [15:0] base,
                                          input logic [3:0]  lg,
                                          input logic [16:0] hdr);
    logic [16:0] align;
    logic [16:0] mask;
    logic [16:0] p;
    logic [16:0] need;
    align = 17'd1 << lg;
    mask  = align - 17'd1;
    p     = align - ({1'b0, base} & mask);
    need  = 17'd0;
    if (p < hdr) begin
      need = hdr - p;
      p    = p + ((need + mask) & ~mask);
    end
    return p;
  endfunction

endpackage

### rtl/fla_ctrl.sv
// Sequencing state machine of the free-list block allocator.
// Depends on fla_pkg; drives commands into fla_dpath.
module fla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fla_pkg::sts_t sts,
  output fla_pkg::cmd_t cmd
);
  import fla_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.st_code = ST_OK;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          KIND_ALLOC: begin
            if (sts.req_bad) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_BAD;
              state_next  = S_DONE;
            end else begin
              cmd.scan_clr = 1'b1;
              state_next   = S_ASCAN;
            end
          end
          KIND_FREE: begin
            cmd.look_clr = 1'b1;
            state_next   = S_FLOOK;
          end
          KIND_RESET: begin
            cmd.pool_reset = 1'b1;
            cmd.st_we      = 1'b1;
            cmd.st_code    = ST_OK;
            state_next     = S_DONE;
          end
          default: begin
            cmd.st_we   = 1'b1;
            cmd.st_code = ST_BAD;
            state_next  = S_DONE;
          end
        endcase
      end
      S_ASCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_ACHK;
      end
      S_ACHK: begin
        cmd.st_we  = 1'b1;
        state_next = S_DONE;
        if (!sts.found) begin
          cmd.st_code = ST_NO_FIT;
        end else if (!sts.slot_avail) begin
          cmd.st_code = ST_FULL;
        end else begin
          cmd.st_code      = ST_OK;
          cmd.alloc_commit = 1'b1;
        end
      end
      S_FLOOK: begin
        cmd.look_step = 1'b1;
        if (sts.look_hit) begin
          state_next = S_FPOS;
        end else if (sts.look_last) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_UNKNOWN;
          state_next  = S_DONE;
        end
      end
      S_FPOS: begin
        cmd.pos_step = 1'b1;
        if (sts.pos_done) state_next = S_FPREV;
      end
      S_FPREV: begin
        cmd.prev_eval = 1'b1;
        state_next    = S_FCHK;
      end
      S_FCHK: begin
        cmd.st_we  = 1'b1;
        state_next = S_DONE;
        if (!sts.jprev && !sts.jnext && sts.table_full) begin
          cmd.st_code = ST_FULL;
        end else begin
          cmd.st_code     = ST_OK;
          cmd.free_commit = 1'b1;
        end
      end
      S_DONE: begin
        // Wait for the output register to free up
        if (!sts.out_busy) begin
          cmd.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/fla_dpath.sv
// Datapath of the free-list block allocator: free-segment table,
// allocation records, fit scan, merge logic and result register.
// Depends on fla_pkg; commanded by fla_ctrl.
module fla_dpath #(
  parameter int FREE_SLOTS   = fla_pkg::FREE_SLOTS_DEF,
  parameter int ALLOC_SLOTS  = fla_pkg::ALLOC_SLOTS_DEF,
  parameter int HEADER_BYTES = fla_pkg::HEADER_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  fla_pkg::cmd_t cmd,
  output fla_pkg::sts_t sts,
  input  logic [1:0]    kind,
  input  logic [15:0]   request_size,
  input  logic [3:0]    align_log2,
  input  logic [15:0]   free_address,
  input  logic          fit_policy,
  input  logic [16:0]   pool_bytes,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    status,
  output logic [15:0]   data_address,
  output logic [16:0]   used_bytes,
  output logic [16:0]   peak_bytes
);
  import fla_pkg::*;

  localparam int FIW = $clog2(FREE_SLOTS);
  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int AIW = $clog2(ALLOC_SLOTS);
  localparam logic [16:0] HB17     = 17'(HEADER_BYTES);
  localparam logic [FCW-1:0] FS_CNT = FCW'(FREE_SLOTS);
  localparam logic [AIW-1:0] AS_LAST = AIW'(ALLOC_SLOTS - 1);

  // Free segment table
  logic [15:0]    fstart [FREE_SLOTS];
  logic [16:0]    flen   [FREE_SLOTS];
  logic [FCW-1:0] fcount;

  // Allocation records
  logic [15:0] adata  [ALLOC_SLOTS];
  logic [15:0] astart [ALLOC_SLOTS];
  logic [16:0] alen   [ALLOC_SLOTS];
  logic [ALLOC_SLOTS-1:0] avalid;

  logic [16:0] used;
  logic [16:0] peak;

  // Request
  kind_t       r_kind;
  logic [15:0] r_size;
  logic [3:0]  r_lg;
  logic [15:0] r_faddr;

  // Scan state
  logic [FCW-1:0] fi;
  logic           p_vld;
  logic [15:0]    p_start;
  logic [16:0]    p_len;
  logic [16:0]    p_pad;
  logic [FIW-1:0] p_idx;
  logic           found;
  logic [FIW-1:0] pick;
  logic [15:0]    pick_start;
  logic [16:0]    pick_need;
  logic [16:0]    pick_pad;
  logic [16:0]    best_rest;

  // Free path state
  logic [AIW-1:0] ai;
  logic [AIW-1:0] rslot;
  logic [15:0]    r_s;
  logic [16:0]    r_len;
  logic           look_hit;
  logic           pos_adv;
  logic [15:0]    nxt_start;
  logic [16:0]    nxt_len;
  logic           jprev;
  logic           jnext;
  logic [16:0]    prev_len;

  // Result
  status_t     res_status;
  logic [15:0] res_addr;
  logic        o_valid;
  status_t     o_status;
  logic [15:0] o_addr;
  logic [16:0] o_used;
  logic [16:0] o_peak;

  // Single read port of the free table
  logic [FIW-1:0] rd_idx;
  logic [15:0]    fs_rd;
  logic [16:0]    fl_rd;
  assign rd_idx = cmd.prev_eval ? FIW'(fi - FCW'(1)) : fi[FIW-1:0];
  assign fs_rd  = fstart[rd_idx];
  assign fl_rd  = flen[rd_idx];

  // Fit check of the entry in the pipeline stage
  logic [17:0] need18;
  logic        fits;
  logic [16:0] rest;
  logic        take;
  assign need18 = {2'b00, r_size} + {1'b0, p_pad};
  assign fits   = {1'b0, p_len} >= need18;
  assign rest   = p_len - need18[16:0];
  assign take   = p_vld && fits && (!found || (fit_policy && rest < best_rest));

  // First free allocation slot
  logic [AIW-1:0] slot;
  logic           slot_avail;
  always_comb begin
    slot       = '0;
    slot_avail = 1'b0;
    for (int i = ALLOC_SLOTS - 1; i >= 0; i--) begin
      if (!avalid[i]) begin
        slot       = AIW'(i);
        slot_avail = 1'b1;
      end
    end
  end

  assign look_hit = avalid[ai] && (adata[ai] == r_faddr);
  assign pos_adv  = (fi < fcount) && !(fs_rd > r_s);

  // Status toward the controller
  always_comb begin
    sts            = '0;
    sts.kind       = r_kind;
    sts.req_bad    = (r_size < MIN_REQUEST) || (r_lg < MIN_ALIGN_LOG2) ||
                     (r_lg > MAX_ALIGN_LOG2);
    sts.scan_done  = (fi >= fcount) && !p_vld;
    sts.found      = found;
    sts.slot_avail = slot_avail;
    sts.look_hit   = look_hit;
    sts.look_last  = (ai == AS_LAST);
    sts.pos_done   = !pos_adv;
    sts.jprev      = jprev;
    sts.jnext      = jnext;
    sts.table_full = (fcount >= FS_CNT);
    sts.out_busy   = o_valid && !out_ready;
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_kind  <= kind_t'(kind);
      r_size  <= request_size;
      r_lg    <= align_log2;
      r_faddr <= free_address;
    end
  end

  // Scan counters, fit pipeline and free lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      found <= 1'b0;
      fi    <= '0;
      ai    <= '0;
    end else begin
      if (cmd.scan_clr) begin
        fi    <= '0;
        p_vld <= 1'b0;
        found <= 1'b0;
      end else if (cmd.scan_step) begin
        p_vld <= fi < fcount;
        if (fi < fcount) begin
          p_start <= fs_rd;
          p_len   <= fl_rd;
          p_pad   <= pad_for(fs_rd, r_lg, HB17);
          p_idx   <= fi[FIW-1:0];
          fi      <= fi + FCW'(1);
        end
        if (take) begin
          found      <= 1'b1;
          pick       <= p_idx;
          pick_start <= p_start;
          pick_need  <= need18[16:0];
          pick_pad   <= p_pad;
          best_rest  <= rest;
        end
      end
      if (cmd.look_clr) begin
        ai <= '0;
      end else if (cmd.look_step) begin
        if (look_hit) begin
          rslot <= ai;
          r_s   <= astart[ai];
          r_len <= alen[ai];
          fi    <= '0;
        end else begin
          ai <= ai + AIW'(1);
        end
      end
      // Position of the first segment past the freed span
      if (cmd.pos_step) begin
        if (pos_adv) begin
          fi <= fi + FCW'(1);
        end else begin
          nxt_start <= fs_rd;
          nxt_len   <= fl_rd;
          jnext     <= (fi < fcount) && (({1'b0, r_s} + r_len) == {1'b0, fs_rd});
        end
      end
      if (cmd.prev_eval) begin
        jprev    <= (fi != '0) && ((fl_rd + {1'b0, fs_rd}) == {1'b0, r_s});
        prev_len <= fl_rd;
      end
    end
  end

  // Free segment table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      fcount    <= FCW'(1);
      fstart[0] <= '0;
      flen[0]   <= POOL_LIM;
    end else if (cmd.pool_reset) begin
      fcount    <= FCW'(1);
      fstart[0] <= '0;
      flen[0]   <= pool_bytes;
    end else if (cmd.alloc_commit) begin
      if (best_rest != '0) begin
        fstart[pick] <= pick_start + pick_need[15:0];
        flen[pick]   <= best_rest;
      end else begin
        for (int k = 0; k < FREE_SLOTS - 1; k++) begin
          if (FIW'(k) >= pick) begin
            fstart[k] <= fstart[k+1];
            flen[k]   <= flen[k+1];
          end
        end
        fcount <= fcount - FCW'(1);
      end
    end else if (cmd.free_commit) begin
      if (jprev && jnext) begin
        for (int k = 0; k < FREE_SLOTS - 1; k++) begin
          if (FCW'(k) >= fi) begin
            fstart[k] <= fstart[k+1];
            flen[k]   <= flen[k+1];
          end
        end
        flen[FIW'(fi - FCW'(1))] <= prev_len + r_len + nxt_len;
        fcount <= fcount - FCW'(1);
      end else if (jprev) begin
        flen[FIW'(fi - FCW'(1))] <= prev_len + r_len;
      end else if (jnext) begin
        fstart[fi[FIW-1:0]] <= r_s;
        flen[fi[FIW-1:0]]   <= nxt_len + r_len;
      end else begin
        for (int k = 1; k < FREE_SLOTS; k++) begin
          if (FCW'(k) > fi) begin
            fstart[k] <= fstart[k-1];
            flen[k]   <= flen[k-1];
          end
        end
        fstart[fi[FIW-1:0]] <= r_s;
        flen[fi[FIW-1:0]]   <= r_len;
        fcount <= fcount + FCW'(1);
      end
    end
  end

  // Allocation valid bits and byte counters
  always_ff @(posedge clk) begin
    if (rst || cmd.pool_reset) begin
      avalid <= '0;
      used   <= '0;
      peak   <= '0;
    end else if (cmd.alloc_commit) begin
      avalid[slot] <= 1'b1;
      used         <= used + pick_need;
      if (used + pick_need > peak) peak <= used + pick_need;
    end else if (cmd.free_commit) begin
      avalid[rslot] <= 1'b0;
      used          <= (used >= r_len) ? used - r_len : '0;
    end
  end

  // Allocation record payload
  always_ff @(posedge clk) begin
    if (cmd.alloc_commit) begin
      adata[slot]  <= pick_start + pick_pad[15:0];
      astart[slot] <= pick_start;
      alen[slot]   <= pick_need;
    end
  end

  // Result of the current request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_addr <= '0;
    end else if (cmd.alloc_commit) begin
      res_addr <= pick_start + pick_pad[15:0];
    end
    if (cmd.st_we) res_status <= cmd.st_code;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.resp_load) begin
      o_valid <= 1'b1;
    end else if (out_ready) begin
      o_valid <= 1'b0;
    end
    if (cmd.resp_load) begin
      o_status <= res_status;
      o_addr   <= res_addr;
      o_used   <= used;
      o_peak   <= peak;
    end
  end

  assign out_valid    = o_valid;
  assign status       = o_status;
  assign data_address = o_addr;
  assign used_bytes   = o_used;
  assign peak_bytes   = o_peak;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fcount <= FS_CNT)
    else $error("free segment count overflow");

  a_peak_ge_used: assert property (@(posedge clk) disable iff (rst)
    peak >= used)
    else $error("peak below used");

  a_alloc_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_commit |=> used > $past(used))
    else $error("allocation did not raise used bytes");

  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd.alloc_commit || cmd.free_commit) |=> res_status == ST_OK)
    else $error("committed request without ok status");

endmodule

### rtl/free_list_block_allocator_unit.sv
// Free-list block allocator: an allocate request scans the free table for a
// fitting segment, and a free request looks up its allocation record and then
// the position of the freed span in the free table; a free of an unknown
// address ends once every allocation record is searched, and a reset or
// rejected request goes straight to its result. The free table and the
// allocation records are each read at one entry per cycle during the scans. A
// finished result sits in an output register so the next request is taken
// while it waits; a request that finishes before the previous result is taken
// holds until then. Depends on fla_pkg, fla_ctrl, fla_dpath.
module free_list_block_allocator_unit #(
  parameter int FREE_SLOTS   = fla_pkg::FREE_SLOTS_DEF,
  parameter int ALLOC_SLOTS  = fla_pkg::ALLOC_SLOTS_DEF,
  parameter int HEADER_BYTES = fla_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] request_size,
  input  logic [3:0]  align_log2,
  input  logic [15:0] free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] data_address,
  output logic [16:0] used_bytes,
  output logic [16:0] peak_bytes,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fla_pkg::*;

  logic        fit_policy;
  logic [16:0] pool_bytes;
  logic [16:0] wr_pool;
  logic        cfg_we;
  cmd_t        cmd;
  sts_t        sts;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    wr_pool = pwdata[16:0];
    if (wr_pool < POOL_MIN) wr_pool = POOL_MIN;
    if (wr_pool > POOL_LIM) wr_pool = POOL_LIM;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= 1'b0;
      pool_bytes <= POOL_LIM;
    end else if (cfg_we) begin
      if (paddr[2] == REG_FIT_POLICY) fit_policy <= pwdata[0];
      else                            pool_bytes <= wr_pool;
    end
  end

  assign prdata = (paddr[2] == REG_POOL_BYTES) ? {15'd0, pool_bytes} : {31'd0, fit_policy};

  fla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fla_dpath #(
    .FREE_SLOTS   (FREE_SLOTS),
    .ALLOC_SLOTS  (ALLOC_SLOTS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .request_size (request_size),
    .align_log2   (align_log2),
    .free_address (free_address),
    .fit_policy   (fit_policy),
    .pool_bytes   (pool_bytes),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .data_address (data_address),
    .used_bytes   (used_bytes),
    .peak_bytes   (peak_bytes)
  );

endmodule
